/* hdl/wpu_pkg.sv */
package wpu_pkg;

  // Bits per sample, as coded in the width register
  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_24 = 2'd2,
    WIDTH_32 = 2'd3
  } width_code_t;

  // Configuration handed from the register block to the datapath
  typedef struct packed {
    width_code_t width_code;
    logic        stereo;
    logic        left_en;
    logic        right_en;
  } wpu_cfg_t;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register byte addresses
  localparam logic [CFG_ADDR_W-1:0] ADDR_WIDTH_CODE = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_STEREO     = 4'h4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LEFT_EN    = 4'h8;
  localparam logic [CFG_ADDR_W-1:0] ADDR_RIGHT_EN   = 4'hC;

  // Reset configuration: 16-bit stereo, both channels on
  localparam wpu_cfg_t CFG_RESET = '{
    width_code: WIDTH_16,
    stereo:     1'b1,
    left_en:    1'b1,
    right_en:   1'b1
  };

endpackage

/* hdl/wpu_unpack.sv */
module wpu_unpack (
  input  logic              clk,
  input  logic              rst_n,
  input  wpu_pkg::wpu_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_sample,
  output logic              out_chan
);
  import wpu_pkg::*;

  logic [2:0]  pos_r, pos_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_sample_r;
  logic        out_chan_r;

  logic [2:0]  nbytes;
  logic [3:0]  frame_len;
  logic [2:0]  pos_eff;
  logic        chan;
  logic [1:0]  lane;
  logic        last_lane;
  logic [3:0]  pos_plus;
  logic [31:0] base;
  logic [31:0] byte_sh;
  logic [31:0] raw;
  logic [31:0] widened;
  logic        chan_en;
  logic        emit;
  logic        in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Locate the byte within the frame
  always_comb begin
    nbytes    = {1'b0, cfg.width_code} + 3'd1;
    frame_len = cfg.stereo ? {nbytes, 1'b0} : {1'b0, nbytes};
    pos_eff   = ({1'b0, pos_r} >= frame_len) ? 3'd0 : pos_r;
    chan      = (pos_eff >= nbytes);
    lane      = chan ? 2'(pos_eff - nbytes) : pos_eff[1:0];
    last_lane = (lane == cfg.width_code);
    pos_plus  = {1'b0, pos_eff} + 4'd1;
    pos_nxt   = (pos_plus >= frame_len) ? 3'd0 : pos_plus[2:0];
  end

  // Merge the byte into the sample under assembly
  always_comb begin
    base = (lane == 2'd0) ? 32'd0 : {8'd0, partial_r};
    case (lane)
      2'd0:    byte_sh = {24'd0, in_byte};
      2'd1:    byte_sh = {16'd0, in_byte, 8'd0};
      2'd2:    byte_sh = {8'd0, in_byte, 16'd0};
      2'd3:    byte_sh = {in_byte, 24'd0};
      default: byte_sh = 32'd0;
    endcase
    raw         = base | byte_sh;
    partial_nxt = last_lane ? 24'd0 : raw[23:0];
  end

  // Left-justify; 8-bit samples are offset binary
  always_comb begin
    case (cfg.width_code)
      WIDTH_8:  widened = {~raw[7], raw[6:0], 24'd0};
      WIDTH_16: widened = {raw[15:0], 16'd0};
      WIDTH_24: widened = {raw[23:0], 8'd0};
      WIDTH_32: widened = raw;
      default:  widened = raw;
    endcase
    chan_en = chan ? (cfg.stereo && cfg.right_en) : cfg.left_en;
    emit    = last_lane && chan_en;
  end

  // Output register: load on a transfer that completes an enabled sample, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 3'd0;
      partial_r   <= 24'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        pos_r     <= pos_nxt;
        partial_r <= partial_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_sample_r <= widened;
      out_chan_r   <= chan;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_chan   = out_chan_r;

  // A completed, enabled sample shows up in the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit) |=> out_valid_r)
    else $error("completed sample not presented");

  // A taken result with no new one leaves the register empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !in_fire) |=> !out_valid_r)
    else $error("result repeated after transfer");

  // A byte inside a sample never wraps the frame position
  a_no_wrap_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !last_lane) |=> (pos_r != 3'd0))
    else $error("frame position wrapped inside a sample");

  // Nothing is emitted for a byte that does not finish a sample
  a_mid_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !last_lane) |=> !out_valid_r)
    else $error("result from an unfinished sample");

endmodule

/* hdl/wav_pcm_sample_unpacker.sv */
// PCM WAV sample unpacker. Feed the data chunk one byte per transfer on the in_
// stream; every completed little-endian sample of an enabled channel comes out on
// the out_ stream as a left-justified signed 32-bit word with its channel in
// out_tuser (0 left or mono, 1 right). One byte is taken in every cycle; a result
// appears in the cycle after the last byte of its sample, from a single output
// register that reloads in the cycle it is taken, so only a stalled out_ side
// holds off input. Set width, stereo and channel enables over the cfg_ port while
// the stream is idle; the frame position is kept across writes.
module wav_pcm_sample_unpacker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,    // [7:0] data_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,   // [31:0] sample_value
  output logic                              out_tuser,   // [0] channel_id
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wpu_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [wpu_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [wpu_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import wpu_pkg::*;

  wpu_cfg_t cfg_r, cfg_nxt;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_paddr)
        ADDR_WIDTH_CODE: cfg_nxt.width_code = width_code_t'(cfg_pwdata[1:0]);
        ADDR_STEREO:     cfg_nxt.stereo     = cfg_pwdata[0];
        ADDR_LEFT_EN:    cfg_nxt.left_en    = cfg_pwdata[0];
        ADDR_RIGHT_EN:   cfg_nxt.right_en   = cfg_pwdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register reads
  always_comb begin
    case (cfg_paddr)
      ADDR_WIDTH_CODE: cfg_prdata = {30'd0, cfg_r.width_code};
      ADDR_STEREO:     cfg_prdata = {31'd0, cfg_r.stereo};
      ADDR_LEFT_EN:    cfg_prdata = {31'd0, cfg_r.left_en};
      ADDR_RIGHT_EN:   cfg_prdata = {31'd0, cfg_r.right_en};
      default:         cfg_prdata = '0;
    endcase
  end

  wpu_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_tdata),
    .out_chan   (out_tuser)
  );

endmodule
